// ----- hw/rtl/atcs_pkg.sv -----
`default_nettype none
package atcs_pkg;

  localparam int SLOTS  = 32;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int FILL_W = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_GRANT  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_STARVE_LIMIT = 2'd0,
    REG_HIGH_WATER   = 2'd1,
    REG_LOW_WATER    = 2'd2,
    REG_THR_CEILING  = 2'd3
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic pop;
    logic scan_init;
    logic scan;
    logic adapt;
    logic load_out;
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic fill_zero;
    logic hit;
    logic scan_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/atcs_datapath.sv -----
`default_nettype none
module atcs_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire atcs_pkg::ctl_cmd_t ctl,
  output atcs_pkg::dp_stat_t      stat,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_idx,
  input  wire logic [15:0]        cfg_wdata,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [4:0]         in_slot,
  input  wire logic [31:0]        in_sent_count,
  input  wire logic [31:0]        in_received_count,
  input  wire logic               in_pending,
  input  wire logic [31:0]        in_now,
  output logic                    out_granted,
  output logic [4:0]              out_grant_slot,
  output logic                    out_rebuilt,
  output logic [15:0]             out_threshold_now,
  output logic [5:0]              out_queue_count,
  output logic                    out_count_error
);
  import atcs_pkg::*;

  logic [15:0] starve_limit_r, ceiling_r;
  logic [5:0]  high_water_r, low_water_r;

  cmd_t        cmd_r;
  logic [SLOT_W-1:0] slot_r;
  logic [31:0] sent_r, recv_r, now_r;
  logic        pend_r;

  logic [SLOTS-1:0] valid_r, spend_r;
  logic [31:0] sent_mem [SLOTS];
  logic [31:0] recv_mem [SLOTS];
  logic [31:0] lg_mem   [SLOTS];
  logic [SLOT_W-1:0] queue_mem [SLOTS];

  logic [SLOT_W-1:0] head_r, idx_r;
  logic [FILL_W-1:0] fill_r;
  logic [15:0] thr_r;
  logic        granted_r, rebuilt_r, cerr_r;
  logic [SLOT_W-1:0] gslot_r;

  logic [SLOT_W-1:0] qslot;
  logic        hit;
  logic        sc_live, sc_neg, sc_starve, sc_take;
  logic [31:0] sc_backlog, sc_age;
  logic [16:0] dbl;

  assign qslot = queue_mem[head_r];
  assign hit   = valid_r[qslot] & spend_r[qslot];

  assign sc_live    = valid_r[idx_r] & spend_r[idx_r];
  assign sc_neg     = recv_mem[idx_r] > sent_mem[idx_r];
  assign sc_age     = now_r - lg_mem[idx_r];
  assign sc_starve  = sc_age > {16'd0, starve_limit_r};
  assign sc_backlog = sc_neg ? 32'd0 : (sent_mem[idx_r] - recv_mem[idx_r]);
  assign sc_take    = sc_live && (sc_starve || sc_backlog >= {16'd0, thr_r})
                      && (fill_r < FILL_W'(SLOTS));

  always_comb begin
    dbl = (thr_r == 16'd0) ? 17'd1 : {thr_r, 1'b0};
    if (dbl > {1'b0, ceiling_r}) dbl = {1'b0, ceiling_r};
  end

  assign stat.cmd       = cmd_r;
  assign stat.fill_zero = (fill_r == '0);
  assign stat.hit       = hit;
  assign stat.scan_last = (idx_r == SLOT_W'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      starve_limit_r <= 16'd10;
      high_water_r   <= 6'd20;
      low_water_r    <= 6'd5;
      ceiling_r      <= 16'd1024;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_STARVE_LIMIT: starve_limit_r <= cfg_wdata;
        REG_HIGH_WATER:   high_water_r   <= cfg_wdata[5:0];
        REG_LOW_WATER:    low_water_r    <= cfg_wdata[5:0];
        REG_THR_CEILING:  ceiling_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // request capture and per-request flags
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r     <= cmd_t'(in_cmd);
      slot_r    <= in_slot;
      sent_r    <= in_sent_count;
      recv_r    <= in_received_count;
      pend_r    <= in_pending;
      now_r     <= in_now;
      granted_r <= 1'b0;
      gslot_r   <= '0;
      rebuilt_r <= 1'b0;
      cerr_r    <= 1'b0;
    end else begin
      if (ctl.exec && cmd_r == CMD_UPDATE && valid_r[slot_r])
        cerr_r <= recv_r > sent_r;
      if (ctl.pop && hit) begin
        granted_r <= 1'b1;
        gslot_r   <= qslot;
      end
      if (ctl.scan && sc_live && sc_neg) cerr_r <= 1'b1;
      if (ctl.adapt) rebuilt_r <= 1'b1;
    end
  end

  // slot table flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      spend_r <= '0;
    end else if (ctl.exec) begin
      unique case (cmd_r)
        CMD_ADD: if (!valid_r[slot_r]) begin
          valid_r[slot_r] <= 1'b1;
          spend_r[slot_r] <= 1'b0;
        end
        CMD_UPDATE: if (valid_r[slot_r]) spend_r[slot_r] <= pend_r;
        CMD_REMOVE: begin
          valid_r[slot_r] <= 1'b0;
          spend_r[slot_r] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // slot counts and grant times
  always_ff @(posedge clk) begin
    if (ctl.exec && cmd_r == CMD_ADD && !valid_r[slot_r]) begin
      sent_mem[slot_r] <= 32'd0;
      recv_mem[slot_r] <= 32'd0;
      lg_mem[slot_r]   <= 32'd0;
    end else if (ctl.exec && cmd_r == CMD_UPDATE && valid_r[slot_r]) begin
      sent_mem[slot_r] <= sent_r;
      recv_mem[slot_r] <= recv_r;
    end else if (ctl.pop && hit) begin
      lg_mem[qslot] <= now_r;
    end
  end

  // grant queue; a rebuild always restarts at entry 0
  always_ff @(posedge clk) begin
    if (ctl.scan && sc_take) queue_mem[fill_r[SLOT_W-1:0]] <= idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
      thr_r  <= 16'd0;
      idx_r  <= '0;
    end else begin
      if (ctl.pop) begin
        head_r <= head_r + 1'b1;
        fill_r <= fill_r - 1'b1;
      end
      if (ctl.scan_init) begin
        head_r <= '0;
        fill_r <= '0;
        idx_r  <= '0;
      end
      if (ctl.scan) begin
        idx_r <= idx_r + 1'b1;
        if (sc_take) fill_r <= fill_r + 1'b1;
      end
      if (ctl.adapt) begin
        priority if (fill_r > high_water_r) begin
          if (thr_r < ceiling_r) thr_r <= dbl[15:0];
        end else if (fill_r < low_water_r) begin
          thr_r <= thr_r >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_granted       <= granted_r;
      out_grant_slot    <= gslot_r;
      out_rebuilt       <= rebuilt_r;
      out_threshold_now <= thr_r;
      out_queue_count   <= fill_r;
      out_count_error   <= cerr_r;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/atcs_ctrl.sv -----
`default_nettype none
module atcs_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire atcs_pkg::dp_stat_t stat,
  output atcs_pkg::ctl_cmd_t      ctl
);
  import atcs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_POP   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_ADAPT = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        ctl.latch = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (stat.cmd == CMD_GRANT) begin
          state_nxt = S_POP;
        end else begin
          ctl.exec  = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_POP: begin
        if (stat.fill_zero) begin
          ctl.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end else begin
          ctl.pop = 1'b1;
          if (stat.hit) state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.scan_last) state_nxt = S_ADAPT;
      end
      S_ADAPT: begin
        ctl.adapt = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: if (out_free) begin
        ctl.load_out = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/adaptive_threshold_conn_scheduler_top.sv -----
// Adaptive-threshold connection scheduler.
// Input channel (in_valid/in_stall) carries one request: add, update, remove
// or grant, with slot, counts, pending flag and current time. Each request
// yields exactly one result on the output channel (out_valid/out_stall).
// The user must write configuration (cfg_we/cfg_idx/cfg_wdata) only while
// idle; the block itself leaves this unenforced.
// A grant pops queue entries until one whose slot is still valid and
// pending is found; if the queue runs empty it rebuilds instead: the
// rebuild scans the slot table one slot per cycle through a single table
// read port, then adapts the threshold.
// One request is in flight at a time; in_stall is high from accept until the
// result is moved to the output register, so a new request can be taken
// while a finished result still waits on a stalled receiver. The output
// register holds its payload while out_stall is high.
// Reset clears the slot table flags, queue, threshold and restores the
// default configuration; no clearing pass is needed.
`default_nettype none
module adaptive_threshold_conn_scheduler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [4:0]  in_slot,
  input  wire logic [31:0] in_sent_count,
  input  wire logic [31:0] in_received_count,
  input  wire logic        in_pending,
  input  wire logic [31:0] in_now,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_granted,
  output logic [4:0]       out_grant_slot,
  output logic             out_rebuilt,
  output logic [15:0]      out_threshold_now,
  output logic [5:0]       out_queue_count,
  output logic             out_count_error,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [15:0] cfg_wdata
);
  import atcs_pkg::*;

  ctl_cmd_t ctl;
  dp_stat_t stat;

  atcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  atcs_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .stat              (stat),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_cmd            (in_cmd),
    .in_slot           (in_slot),
    .in_sent_count     (in_sent_count),
    .in_received_count (in_received_count),
    .in_pending        (in_pending),
    .in_now            (in_now),
    .out_granted       (out_granted),
    .out_grant_slot    (out_grant_slot),
    .out_rebuilt       (out_rebuilt),
    .out_threshold_now (out_threshold_now),
    .out_queue_count   (out_queue_count),
    .out_count_error   (out_count_error)
  );

  a_no_grant_and_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_granted && out_rebuilt))
    else $error("grant and rebuild in one result");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_queue_count <= 6'd32))
    else $error("queue count beyond table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken while one is in flight");

  a_single_datapath_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ctl))
    else $error("controller issued overlapping commands");

endmodule
`default_nettype wire
